/* rtl/rfts_pkg.sv */
// Shared types and constants for the ring queue with time sort.
// No dependencies; the sorter, the core and both test files import this package.
`default_nettype none

package rfts_pkg;

    // Default ring depth; one slot always stays free.
    localparam int RFTS_SLOTS = 64;

    // Width of the occupancy field on the result channel.
    localparam int OCC_W = 6;

    // Action codes.
    localparam logic [1:0] ACT_STORE = 2'd0;
    localparam logic [1:0] ACT_TAKE  = 2'd1;
    localparam logic [1:0] ACT_SORT  = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // One queue entry; the low 17 bits form the time key.
    typedef struct packed {
        logic [15:0] message_ref;
        logic [7:0]  sender_id;
        logic [7:0]  color_code;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } t_entry;

    localparam int KEY_W = 17;

    // One result transfer.
    typedef struct packed {
        logic [1:0]       status;
        t_entry           entry;
        logic [OCC_W-1:0] occupancy;
    } t_result;

    // Memory write strobes driven by the sort sequencer.
    typedef struct packed {
        logic store_we;
        logic scratch_we;
    } t_sort_we;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_TAKE,
        TOP_SORT
    } t_top_state;

    typedef enum logic [2:0] {
        SRT_IDLE,
        SRT_SETUP,
        SRT_FETCH,
        SRT_MERGE,
        SRT_COPY_RD,
        SRT_COPY_WR,
        SRT_NEXT
    } t_sort_state;

endpackage

`default_nettype wire

/* rtl/rfts_in_if.sv */
// Input channel of the ring queue: valid/ready handshake and action payload.
// No dependencies.
`default_nettype none

interface rfts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] message_ref;
    logic [7:0]  sender_id;
    logic [7:0]  color_code;
    logic [4:0]  stamp_hours;
    logic [5:0]  stamp_minutes;
    logic [5:0]  stamp_seconds;

    modport source (
        output valid, action, message_ref, sender_id, color_code,
               stamp_hours, stamp_minutes, stamp_seconds,
        input  ready
    );

    modport sink (
        input  valid, action, message_ref, sender_id, color_code,
               stamp_hours, stamp_minutes, stamp_seconds,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/rfts_out_if.sv */
// Result channel of the ring queue: valid/ready handshake and result payload.
// No dependencies.
`default_nettype none

interface rfts_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_message_ref;
    logic [7:0]  out_sender_id;
    logic [7:0]  out_color_code;
    logic [4:0]  out_hours;
    logic [5:0]  out_minutes;
    logic [5:0]  out_seconds;
    logic [5:0]  occupancy;

    modport source (
        output valid, status, out_message_ref, out_sender_id, out_color_code,
               out_hours, out_minutes, out_seconds, occupancy,
        input  ready
    );

    modport sink (
        input  valid, status, out_message_ref, out_sender_id, out_color_code,
               out_hours, out_minutes, out_seconds, occupancy,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/rfts_sorter.sv */
// Bottom-up merge sort sequencer over the ring memory and the scratch memory.
// Depends on rfts_pkg; the memories themselves live in the top level.
`default_nettype none

module rfts_sorter #(
    parameter int RING_SLOTS = rfts_pkg::RFTS_SLOTS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [$clog2(RING_SLOTS)-1:0]    i_count,
    input  wire logic [$clog2(RING_SLOTS)-1:0]    i_head,
    input  wire rfts_pkg::t_entry                 i_st_rd_a,
    input  wire rfts_pkg::t_entry                 i_st_rd_b,
    input  wire rfts_pkg::t_entry                 i_sc_rd,
    output logic [$clog2(RING_SLOTS)-1:0]         o_st_ra,
    output logic [$clog2(RING_SLOTS)-1:0]         o_st_rb,
    output logic [$clog2(RING_SLOTS)-1:0]         o_st_wa,
    output rfts_pkg::t_entry                      o_st_wd,
    output logic [$clog2(RING_SLOTS)-1:0]         o_sc_ra,
    output logic [$clog2(RING_SLOTS)-1:0]         o_sc_wa,
    output rfts_pkg::t_entry                      o_sc_wd,
    output rfts_pkg::t_sort_we                    o_we,
    output logic                                  o_done
);
    import rfts_pkg::*;

    localparam int ADDR_W = $clog2(RING_SLOTS);
    // Positions, run bounds and widths stay below four times the depth.
    localparam int POS_W  = ADDR_W + 2;
    localparam logic [POS_W-1:0] SLOTS_P = POS_W'(RING_SLOTS);

    t_sort_state r_state, n_state;
    logic [POS_W-1:0]  r_n, n_n;
    logic [POS_W-1:0]  r_width, n_width;
    logic [POS_W-1:0]  r_lo, n_lo;
    logic [POS_W-1:0]  r_mid, n_mid;
    logic [POS_W-1:0]  r_hi, n_hi;
    logic [POS_W-1:0]  r_i, n_i;
    logic [POS_W-1:0]  r_j, n_j;
    logic [POS_W-1:0]  r_k, n_k;
    logic [ADDR_W-1:0] r_head, n_head;

    logic [POS_W-1:0]  lo_end;
    logic [POS_W-1:0]  lo_next;
    logic [POS_W-1:0]  width_dbl;
    logic              a_live;
    logic              b_live;
    logic              take_a;

    // Logical position to ring slot: one compare and subtract.
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                  input logic [POS_W-1:0]  pos);
        logic [POS_W-1:0] sum;
        sum = POS_W'(head) + pos;
        if (sum >= SLOTS_P) begin
            sum = sum - SLOTS_P;
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] time_key(input t_entry e);
        return {e.hours, e.minutes, e.seconds};
    endfunction

    // Memory addresses follow the run cursors.
    assign o_st_ra = slot_of(r_head, r_i);
    assign o_st_rb = slot_of(r_head, r_j);
    assign o_st_wa = slot_of(r_head, r_k);
    assign o_sc_ra = r_k[ADDR_W-1:0];
    assign o_sc_wa = r_k[ADDR_W-1:0];
    assign o_st_wd = i_sc_rd;

    assign width_dbl = r_width << 1;
    assign lo_end    = r_lo + width_dbl;
    assign lo_next   = lo_end + r_width;
    assign a_live    = (r_i < r_mid);
    assign b_live    = (r_j < r_hi);
    // On equal keys the right run goes first.
    assign take_a    = a_live && (!b_live || (time_key(i_st_rd_a) < time_key(i_st_rd_b)));
    assign o_sc_wd   = take_a ? i_st_rd_a : i_st_rd_b;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SRT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Cursor registers
    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_width <= n_width;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_head  <= n_head;
    end

    // Next state and memory strobes
    always_comb begin
        n_state        = r_state;
        n_n            = r_n;
        n_width        = r_width;
        n_lo           = r_lo;
        n_mid          = r_mid;
        n_hi           = r_hi;
        n_i            = r_i;
        n_j            = r_j;
        n_k            = r_k;
        n_head         = r_head;
        o_we.store_we   = 1'b0;
        o_we.scratch_we = 1'b0;
        o_done         = 1'b0;

        unique case (r_state)
            SRT_IDLE: begin
                if (i_start) begin
                    n_n     = POS_W'(i_count);
                    n_head  = i_head;
                    n_width = POS_W'(1);
                    n_lo    = '0;
                    n_state = SRT_SETUP;
                end
            end
            SRT_SETUP: begin
                n_mid   = r_lo + r_width;
                n_hi    = (lo_end > r_n) ? r_n : lo_end;
                n_i     = r_lo;
                n_j     = r_lo + r_width;
                n_k     = r_lo;
                n_state = SRT_FETCH;
            end
            SRT_FETCH: begin
                // both runs drained: copy the merged run back
                if (!a_live && !b_live) begin
                    n_k     = r_lo;
                    n_state = SRT_COPY_RD;
                end else begin
                    n_state = SRT_MERGE;
                end
            end
            SRT_MERGE: begin
                o_we.scratch_we = 1'b1;
                n_k = r_k + POS_W'(1);
                if (take_a) begin
                    n_i = r_i + POS_W'(1);
                end else begin
                    n_j = r_j + POS_W'(1);
                end
                n_state = SRT_FETCH;
            end
            SRT_COPY_RD: begin
                n_state = SRT_COPY_WR;
            end
            SRT_COPY_WR: begin
                o_we.store_we = 1'b1;
                n_k = r_k + POS_W'(1);
                if (r_k + POS_W'(1) == r_hi) begin
                    n_state = SRT_NEXT;
                end else begin
                    n_state = SRT_COPY_RD;
                end
            end
            SRT_NEXT: begin
                if (lo_next < r_n) begin
                    n_lo    = lo_end;
                    n_state = SRT_SETUP;
                end else if (width_dbl < r_n) begin
                    n_width = width_dbl;
                    n_lo    = '0;
                    n_state = SRT_SETUP;
                end else begin
                    o_done  = 1'b1;
                    n_state = SRT_IDLE;
                end
            end
            default: begin
                n_state = SRT_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/ring_fifo_with_time_sort_core.sv */
// Ring queue with in-place time sort. Store, unused and refused actions: result valid
// in the cycle after the input transfer; take: the result passes the take state (one ring memory read).
// Sort of n > 1 entries: each element goes into scratch through fetch and merge and
// back through copy read and copy write; each merge also passes setup, a closing fetch and next.
// One action is in flight at a time. Synchronous reset clears head, tail and
// count; the memories are not cleared and need no clearing pass.
`default_nettype none

module ring_fifo_with_time_sort_core #(
    parameter int RING_SLOTS = rfts_pkg::RFTS_SLOTS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rfts_in_if.sink    i_in,
    rfts_out_if.source o_out
);
    import rfts_pkg::*;

    localparam int ADDR_W = $clog2(RING_SLOTS);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(RING_SLOTS - 1);

    t_top_state        r_state, n_state;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;
    logic [ADDR_W-1:0] r_count, n_count;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    // Ring and scratch memories
    t_entry            r_store_mem   [RING_SLOTS];
    t_entry            r_scratch_mem [RING_SLOTS];
    t_entry            r_st_qa, r_st_qb, r_sc_q;

    logic              st_we;
    logic [ADDR_W-1:0] st_wa, st_ra;
    t_entry            st_wd;

    logic [ADDR_W-1:0] srt_st_ra, srt_st_rb, srt_st_wa, srt_sc_ra, srt_sc_wa;
    t_entry            srt_st_wd, srt_sc_wd;
    t_sort_we          srt_we;
    logic              srt_done;
    logic              srt_start;

    logic              accept;
    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] tail_inc;
    logic [ADDR_W-1:0] head_inc;
    t_entry            in_entry;
    logic [OCC_W-1:0]  occ_now;

    assign tail_inc = (r_tail == LAST_SLOT) ? '0 : r_tail + ADDR_W'(1);
    assign head_inc = (r_head == LAST_SLOT) ? '0 : r_head + ADDR_W'(1);
    assign full     = (tail_inc == r_head);
    assign empty    = (r_head == r_tail);
    assign occ_now  = OCC_W'(r_count);

    assign in_entry = '{message_ref: i_in.message_ref, sender_id: i_in.sender_id,
                        color_code: i_in.color_code, hours: i_in.stamp_hours,
                        minutes: i_in.stamp_minutes, seconds: i_in.stamp_seconds};

    // Input side: one action at a time, result register free or draining
    assign i_in.ready = (r_state == TOP_IDLE) && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;
    assign srt_start  = accept && (i_in.action == ACT_SORT) && !empty
                        && (r_count > ADDR_W'(1));

    // Ring memory port mux: sequencer owns it while sorting
    assign st_we = (r_state == TOP_SORT) ? srt_we.store_we
                 : (accept && (i_in.action == ACT_STORE) && !full);
    assign st_wa = (r_state == TOP_SORT) ? srt_st_wa : r_tail;
    assign st_wd = (r_state == TOP_SORT) ? srt_st_wd : in_entry;
    assign st_ra = (r_state == TOP_SORT) ? srt_st_ra : r_head;

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store_mem[st_wa] <= st_wd;
        end
        r_st_qa <= r_store_mem[st_ra];
        r_st_qb <= r_store_mem[srt_st_rb];
    end

    always_ff @(posedge i_clk) begin
        if (srt_we.scratch_we) begin
            r_scratch_mem[srt_sc_wa] <= srt_sc_wd;
        end
        r_sc_q <= r_scratch_mem[srt_sc_ra];
    end

    rfts_sorter #(
        .RING_SLOTS (RING_SLOTS)
    ) u_sorter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (srt_start),
        .i_count   (r_count),
        .i_head    (r_head),
        .i_st_rd_a (r_st_qa),
        .i_st_rd_b (r_st_qb),
        .i_sc_rd   (r_sc_q),
        .o_st_ra   (srt_st_ra),
        .o_st_rb   (srt_st_rb),
        .o_st_wa   (srt_st_wa),
        .o_st_wd   (srt_st_wd),
        .o_sc_ra   (srt_sc_ra),
        .o_sc_wa   (srt_sc_wa),
        .o_sc_wd   (srt_sc_wd),
        .o_we      (srt_we),
        .o_done    (srt_done)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TOP_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Action decode, pointer update and result formation
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;

        unique case (r_state)
            TOP_IDLE: begin
                if (accept) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = STAT_DONE;
                    n_out.entry      = '0;
                    n_out.occupancy  = occ_now;
                    case (i_in.action)
                        ACT_STORE: begin
                            if (full) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                n_tail          = tail_inc;
                                n_count         = r_count + ADDR_W'(1);
                                n_out.occupancy = OCC_W'(r_count + ADDR_W'(1));
                            end
                        end
                        ACT_TAKE: begin
                            if (empty) begin
                                n_out.status = STAT_EMPTY;
                            end else begin
                                // result waits for the ring read
                                n_out_valid = 1'b0;
                                n_head      = head_inc;
                                n_count     = r_count - ADDR_W'(1);
                                n_state     = TOP_TAKE;
                            end
                        end
                        ACT_SORT: begin
                            if (empty) begin
                                n_out.status = STAT_EMPTY;
                            end else if (srt_start) begin
                                n_out_valid = 1'b0;
                                n_state     = TOP_SORT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            TOP_TAKE: begin
                n_out_valid     = 1'b1;
                n_out.status    = STAT_DONE;
                n_out.entry     = r_st_qa;
                n_out.occupancy = occ_now;
                n_state         = TOP_IDLE;
            end
            TOP_SORT: begin
                if (srt_done) begin
                    n_out_valid     = 1'b1;
                    n_out.status    = STAT_DONE;
                    n_out.entry     = '0;
                    n_out.occupancy = occ_now;
                    n_state         = TOP_IDLE;
                end
            end
            default: begin
                n_state = TOP_IDLE;
            end
        endcase
    end

    // Result channel
    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.out_message_ref = r_out.entry.message_ref;
    assign o_out.out_sender_id   = r_out.entry.sender_id;
    assign o_out.out_color_code  = r_out.entry.color_code;
    assign o_out.out_hours       = r_out.entry.hours;
    assign o_out.out_minutes     = r_out.entry.minutes;
    assign o_out.out_seconds     = r_out.entry.seconds;
    assign o_out.occupancy       = r_out.occupancy;

endmodule

`default_nettype wire

/* test/rfts_checker.sv */
// Scoreboard for the ring queue with time sort: watches both channels, predicts
// each result from a private copy of the queue and compares field by field.
// Depends on rfts_pkg and the rfts_in_if / rfts_out_if interfaces.
module rfts_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rfts_in_if        i_act,
    rfts_out_if       i_res,
    output int        o_mismatches,
    output int        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import rfts_pkg::*;

    localparam int MAX_REPORTS = 40;

    // Private copy of the queue
    t_entry ring_mem [RFTS_SLOTS];
    int     head_pos;
    int     tail_pos;
    int     live_entries;

    // Results still owed by the block, oldest first
    t_result expected_results [$];

    int mismatch_count;
    int results_checked;

    // Activity tallies for the closing summary
    int n_stores;
    int n_takes;
    int n_sorts;
    int n_full;
    int n_empty;
    int n_unused;
    int largest_sort;

    function automatic logic [KEY_W-1:0] time_key(t_entry e);
        return {e.hours, e.minutes, e.seconds};
    endfunction

    // Bottom-up merge sort over the live entries in queue order.
    // Ties: the entry from the right run goes first.
    function automatic void sort_by_time();
        t_entry runs   [RFTS_SLOTS];
        t_entry merged [RFTS_SLOTS];
        int n, w, lo, mid, hi, i, j, k;
        n = live_entries;
        for (k = 0; k < n; k++)
            runs[k] = ring_mem[(head_pos + k) % RFTS_SLOTS];
        for (w = 1; w < n; w = w * 2) begin
            for (lo = 0; lo + w < n; lo = lo + 2 * w) begin
                mid = lo + w;
                hi  = (lo + 2 * w > n) ? n : lo + 2 * w;
                i = lo;
                j = mid;
                k = lo;
                while (i < mid && j < hi) begin
                    if (time_key(runs[i]) < time_key(runs[j])) begin
                        merged[k] = runs[i];
                        i++;
                    end else begin
                        merged[k] = runs[j];
                        j++;
                    end
                    k++;
                end
                while (i < mid) begin
                    merged[k] = runs[i];
                    i++;
                    k++;
                end
                while (j < hi) begin
                    merged[k] = runs[j];
                    j++;
                    k++;
                end
                for (k = lo; k < hi; k++)
                    runs[k] = merged[k];
            end
        end
        for (k = 0; k < n; k++)
            ring_mem[(head_pos + k) % RFTS_SLOTS] = runs[k];
    endfunction

    // Apply one action to the private queue and return the result it owes.
    function automatic t_result predict_queue_action(logic [1:0] act, t_entry incoming);
        t_result res;
        res = '0;
        res.status = STAT_DONE;
        case (act)
            ACT_STORE: begin
                if ((tail_pos + 1) % RFTS_SLOTS == head_pos) begin
                    res.status = STAT_FULL;
                    n_full++;
                end else begin
                    ring_mem[tail_pos] = incoming;
                    tail_pos = (tail_pos + 1) % RFTS_SLOTS;
                    live_entries++;
                    n_stores++;
                end
            end
            ACT_TAKE: begin
                if (head_pos == tail_pos) begin
                    res.status = STAT_EMPTY;
                    n_empty++;
                end else begin
                    res.entry = ring_mem[head_pos];
                    head_pos = (head_pos + 1) % RFTS_SLOTS;
                    live_entries--;
                    n_takes++;
                end
            end
            ACT_SORT: begin
                if (head_pos == tail_pos) begin
                    res.status = STAT_EMPTY;
                    n_empty++;
                end else begin
                    sort_by_time();
                    n_sorts++;
                    if (live_entries > largest_sort)
                        largest_sort = live_entries;
                end
            end
            default: n_unused++;   // unused code: no change
        endcase
        res.occupancy = OCC_W'(live_entries);
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
                     $realtime, results_checked, what, got, want);
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing pending, status", i_res.status, 0);
        end else begin
            want = expected_results.pop_front();
            if (i_res.status != want.status)
                report_mismatch("status", i_res.status, want.status);
            if (i_res.out_message_ref != want.entry.message_ref)
                report_mismatch("message_ref", i_res.out_message_ref, want.entry.message_ref);
            if (i_res.out_sender_id != want.entry.sender_id)
                report_mismatch("sender_id", i_res.out_sender_id, want.entry.sender_id);
            if (i_res.out_color_code != want.entry.color_code)
                report_mismatch("color_code", i_res.out_color_code, want.entry.color_code);
            if (i_res.out_hours != want.entry.hours)
                report_mismatch("hours", i_res.out_hours, want.entry.hours);
            if (i_res.out_minutes != want.entry.minutes)
                report_mismatch("minutes", i_res.out_minutes, want.entry.minutes);
            if (i_res.out_seconds != want.entry.seconds)
                report_mismatch("seconds", i_res.out_seconds, want.entry.seconds);
            if (i_res.occupancy != want.occupancy)
                report_mismatch("occupancy", i_res.occupancy, want.occupancy);
        end
        results_checked++;
    endtask

    task automatic print_summary();
        $display("Covered %0d stores, %0d takes, %0d sorts (largest %0d entries), %0d results",
                 n_stores, n_takes, n_sorts, largest_sort, results_checked);
        $display("Refusals: %0d on full queue, %0d on empty queue; %0d unused action codes",
                 n_full, n_empty, n_unused);
    endtask

    // Watch both channels; results first, then the new action
    always @(posedge i_clk) begin
        t_entry incoming;
        if (!i_rst_n) begin
            head_pos     = 0;
            tail_pos     = 0;
            live_entries = 0;
            expected_results.delete();
        end else begin
            if (i_res.valid && i_res.ready)
                check_result();
            if (i_act.valid && i_act.ready) begin
                incoming.message_ref = i_act.message_ref;
                incoming.sender_id   = i_act.sender_id;
                incoming.color_code  = i_act.color_code;
                incoming.hours       = i_act.stamp_hours;
                incoming.minutes     = i_act.stamp_minutes;
                incoming.seconds     = i_act.stamp_seconds;
                expected_results.push_back(predict_queue_action(i_act.action, incoming));
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_results.size();
    end

endmodule

/* test/tb.sv */
// Top of the ring queue testbench: clock, reset, action stimulus, result-side
// back-pressure and the verdict. Depends on rfts_pkg, both channel interfaces,
// ring_fifo_with_time_sort_core and rfts_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfts_pkg::*;

    localparam int          CYCLE_LIMIT  = 8_000_000;
    localparam int          RESET_CYCLES = 6;
    localparam int          TOTAL_ITEMS  = 1250;
    localparam int          MAX_GAP      = 18;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 32;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;

    typedef enum int {
        PH_FILL,
        PH_MIXED,
        PH_DRAIN
    } t_phase;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] message_ref;
        logic [7:0]  sender_id;
        logic [7:0]  color_code;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } t_request;

    logic i_clk;
    logic i_rst_n;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int items_sent  = 0;

    // Sender idle pattern: stretches of back-to-back items between gappy ones
    int calm_items_left = 0;
    bit sender_calm     = 1'b0;

    rfts_in_if  in_ch ();
    rfts_out_if out_ch ();

    ring_fifo_with_time_sort_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rfts_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_act         (in_ch),
        .i_res         (out_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_request mk_request(logic [1:0] act, logic [15:0] msg,
                                            logic [7:0] snd, logic [7:0] col,
                                            logic [4:0] hh, logic [5:0] mm,
                                            logic [5:0] ss);
        t_request req;
        req.action      = act;
        req.message_ref = msg;
        req.sender_id   = snd;
        req.color_code  = col;
        req.hours       = hh;
        req.minutes     = mm;
        req.seconds     = ss;
        return req;
    endfunction

    // Action mix depends on the phase; times often collide to exercise ties
    function automatic t_request random_request(t_phase ph);
        t_request req;
        int pick;
        int tsel;
        pick = $urandom_range(0, 99);
        case (ph)
            PH_FILL:  req.action = (pick < 80) ? ACT_STORE : (pick < 89) ? ACT_TAKE :
                                   (pick < 98) ? ACT_SORT : ACT_UNUSED;
            PH_DRAIN: req.action = (pick < 12) ? ACT_STORE : (pick < 90) ? ACT_TAKE :
                                   (pick < 98) ? ACT_SORT : ACT_UNUSED;
            default:  req.action = (pick < 46) ? ACT_STORE : (pick < 88) ? ACT_TAKE :
                                   (pick < 98) ? ACT_SORT : ACT_UNUSED;
        endcase
        req.message_ref = 16'($urandom);
        req.sender_id   = 8'($urandom);
        req.color_code  = 8'($urandom);
        tsel = $urandom_range(0, 9);
        if (tsel < 3) begin
            req.hours   = 5'($urandom_range(0, 1));
            req.minutes = 6'($urandom_range(0, 1));
            req.seconds = 6'($urandom_range(0, 2));
        end else if (tsel < 9) begin
            req.hours   = 5'($urandom_range(0, 23));
            req.minutes = 6'($urandom_range(0, 59));
            req.seconds = 6'($urandom_range(0, 59));
        end else begin
            // out-of-range times still order by raw bits
            req.hours   = 5'($urandom_range(0, 31));
            req.minutes = 6'($urandom_range(0, 63));
            req.seconds = 6'($urandom_range(0, 63));
        end
        return req;
    endfunction

    // Offer one action after a random gap and wait for its transfer
    task automatic send_request(input t_request req);
        int gap;
        if (calm_items_left == 0) begin
            calm_items_left = $urandom_range(20, 80);
            sender_calm     = ($urandom_range(0, 2) == 0);
        end
        calm_items_left--;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= req.action;
        in_ch.message_ref   <= req.message_ref;
        in_ch.sender_id     <= req.sender_id;
        in_ch.color_code    <= req.color_code;
        in_ch.stamp_hours   <= req.hours;
        in_ch.stamp_minutes <= req.minutes;
        in_ch.stamp_seconds <= req.seconds;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Stop offering until every pending result has come back
    task automatic wait_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, calm stretches, and two long hold-offs
    initial begin
        int stall;
        int taken;
        int calm_left;
        bit calm;
        taken     = 0;
        calm_left = 0;
        calm      = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            if (taken == 40 || taken == 700) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (calm_left == 0) begin
                    calm_left = $urandom_range(20, 80);
                    calm      = ($urandom_range(0, 2) == 0);
                end
                calm_left--;
                stall = calm ? 0 : $urandom_range(0, MAX_GAP);
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            taken++;
        end
    end

    // Action side: reset, directed actions, then phased random traffic
    initial begin
        t_request directed [$];
        t_phase   phase;
        int       phase_len;
        int       phase_idx;

        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.action        <= ACT_STORE;
        in_ch.message_ref   <= '0;
        in_ch.sender_id     <= '0;
        in_ch.color_code    <= '0;
        in_ch.stamp_hours   <= '0;
        in_ch.stamp_minutes <= '0;
        in_ch.stamp_seconds <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // refusals and the unused code on an empty queue
        directed.push_back(mk_request(ACT_TAKE,   16'h1234, 8'h01, 8'h02, 5'd3, 6'd4, 6'd5));
        directed.push_back(mk_request(ACT_SORT,   16'hFFFF, 8'hFF, 8'hFF, 5'd31, 6'd63, 6'd63));
        directed.push_back(mk_request(ACT_UNUSED, 16'hA5A5, 8'h5A, 8'hC3, 5'd9, 6'd9, 6'd9));
        // field extremes, ties and out-of-range times
        directed.push_back(mk_request(ACT_STORE,  16'h0000, 8'h00, 8'h00, 5'd0, 6'd0, 6'd0));
        directed.push_back(mk_request(ACT_STORE,  16'hFFFF, 8'hFF, 8'hFF, 5'd31, 6'd63, 6'd63));
        directed.push_back(mk_request(ACT_STORE,  16'hFFFF, 8'h00, 8'hFF, 5'd23, 6'd59, 6'd59));
        directed.push_back(mk_request(ACT_STORE,  16'h0001, 8'h11, 8'h21, 5'd12, 6'd30, 6'd30));
        directed.push_back(mk_request(ACT_STORE,  16'h0002, 8'h12, 8'h22, 5'd12, 6'd30, 6'd30));
        directed.push_back(mk_request(ACT_STORE,  16'h0003, 8'h13, 8'h23, 5'd12, 6'd30, 6'd30));
        directed.push_back(mk_request(ACT_STORE,  16'h8000, 8'h80, 8'h80, 5'd0, 6'd0, 6'd1));
        directed.push_back(mk_request(ACT_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 5'd31, 6'd63, 6'd63));
        directed.push_back(mk_request(ACT_SORT,   16'h0000, 8'h00, 8'h00, 5'd0, 6'd0, 6'd0));
        repeat (7)
            directed.push_back(mk_request(ACT_TAKE, 16'h5555, 8'hAA, 8'h55, 5'd21, 6'd42, 6'd21));
        directed.push_back(mk_request(ACT_TAKE,   16'h0000, 8'h00, 8'h00, 5'd0, 6'd0, 6'd0));
        // sort of a single entry
        directed.push_back(mk_request(ACT_STORE,  16'h0505, 8'h05, 8'h05, 5'd5, 6'd5, 6'd5));
        directed.push_back(mk_request(ACT_SORT,   16'h0000, 8'h00, 8'h00, 5'd0, 6'd0, 6'd0));
        directed.push_back(mk_request(ACT_TAKE,   16'h0000, 8'h00, 8'h00, 5'd0, 6'd0, 6'd0));

        foreach (directed[n])
            send_request(directed[n]);
        wait_until_drained();

        // fill, mix and drain in turn; every fourth phase ends fully drained
        phase_idx = 0;
        while (items_sent < TOTAL_ITEMS) begin
            phase     = t_phase'(phase_idx % 3);
            phase_len = (phase == PH_MIXED) ? $urandom_range(60, 120)
                                            : $urandom_range(90, 140);
            for (int n = 0; n < phase_len && items_sent < TOTAL_ITEMS; n++)
                send_request(random_request(phase));
            phase_idx++;
            if (phase_idx % 4 == 0)
                wait_until_drained();
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        u_checker.print_summary();
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
